/* src/spc_pkg.sv */
// Package for the shape pair collision test.
// Holds the shape kind codes and the default coordinate width; no dependencies.
package spc_pkg;

   localparam int KIND_WIDTH = 2;
   localparam int COORD_WIDTH_DEFAULT = 16;

   typedef logic [KIND_WIDTH-1:0] kind_type;

   localparam kind_type KIND_RECT   = 2'd0;
   localparam kind_type KIND_SEG    = 2'd1;
   localparam kind_type KIND_CIRCLE = 2'd2;

endpackage

/* src/spc_req_if.sv */
// Request channel carrying one shape pair per transaction.
// Depends on spc_pkg for the kind type.
interface spc_req_if #(parameter int COORD_WIDTH = 16);
   import spc_pkg::*;

   logic                          valid;
   logic                          ready;
   kind_type                      kind_a;
   logic signed [COORD_WIDTH-1:0] ax;
   logic signed [COORD_WIDTH-1:0] ay;
   logic signed [COORD_WIDTH-1:0] ap;
   logic signed [COORD_WIDTH-1:0] aq;
   kind_type                      kind_b;
   logic signed [COORD_WIDTH-1:0] bx;
   logic signed [COORD_WIDTH-1:0] by;
   logic signed [COORD_WIDTH-1:0] bp;
   logic signed [COORD_WIDTH-1:0] bq;

   modport source (output valid, kind_a, ax, ay, ap, aq, kind_b, bx, by, bp, bq,
                   input ready);
   modport sink (input valid, kind_a, ax, ay, ap, aq, kind_b, bx, by, bp, bq,
                 output ready);
endinterface

/* src/spc_rsp_if.sv */
// Response channel carrying the collision bit of one shape pair per transaction.
// No dependencies.
interface spc_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

/* src/shape_pair_collision_test.sv */
// Shape pair collision test, top level: input register, evaluation, result register.
// Depends on spc_pkg, spc_req_if, spc_rsp_if and spc_pair_eval.
//
// Takes one shape pair per transaction and returns one hit bit per pair, in
// order. A new pair is taken every cycle unless both registers are full and the
// result is not being taken; a pair accepted into the input register is evaluated
// and its hit is offered from the result register. The whole test runs in one pass of
// logic between the input register and the result register, with four
// cross-product segment-test units and one squared-distance unit for
// circles, so that pass sets the clock. The result register takes a new value
// whenever it is empty or being taken, so both sides can stall independently.
module shape_pair_collision_test #(
   parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   spc_req_if.sink   req_bus,
   spc_rsp_if.source rsp_bus
);
   import spc_pkg::*;

   logic                          stg_valid_ff, stg_valid_in;
   kind_type                      kind_a_ff, kind_b_ff;
   logic signed [COORD_WIDTH-1:0] ax_ff, ay_ff, ap_ff, aq_ff;
   logic signed [COORD_WIDTH-1:0] bx_ff, by_ff, bp_ff, bq_ff;
   logic                          out_valid_ff, out_valid_in;
   logic                          hit_ff, hit_in;
   logic                          out_ready, stg_ready, stg_load;

   assign out_ready = !out_valid_ff || rsp_bus.ready;
   assign stg_ready = !stg_valid_ff || out_ready;
   assign stg_load  = req_bus.valid && stg_ready;

   assign req_bus.ready = stg_ready;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.hit   = hit_ff;

   assign stg_valid_in = stg_ready ? req_bus.valid : stg_valid_ff;
   assign out_valid_in = out_ready ? stg_valid_ff : out_valid_ff;

   spc_pair_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval (
      .kind_a(kind_a_ff), .ax(ax_ff), .ay(ay_ff), .ap(ap_ff), .aq(aq_ff),
      .kind_b(kind_b_ff), .bx(bx_ff), .by(by_ff), .bp(bp_ff), .bq(bq_ff),
      .hit(hit_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_load) begin
         kind_a_ff <= req_bus.kind_a;
         ax_ff     <= req_bus.ax;
         ay_ff     <= req_bus.ay;
         ap_ff     <= req_bus.ap;
         aq_ff     <= req_bus.aq;
         kind_b_ff <= req_bus.kind_b;
         bx_ff     <= req_bus.bx;
         by_ff     <= req_bus.by;
         bp_ff     <= req_bus.bp;
         bq_ff     <= req_bus.bq;
      end
      if (out_ready && stg_valid_ff) begin
         hit_ff <= hit_in;
      end
   end

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !stg_valid_ff |-> req_bus.ready)
      else $error("empty input stage refuses a transaction");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && out_ready |=> rsp_bus.valid)
      else $error("evaluated pair did not reach the result register");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !out_ready |=> stg_valid_ff && $stable(hit_in))
      else $error("stalled pair lost from the input stage");
endmodule

/* src/spc_seg_test.sv */
// Exact segment-segment intersection test by cross products.
// Parallel or collinear pairs give no hit. Uses no package items.
module spc_seg_test #(
   parameter int POINT_WIDTH = 17
) (
   input  logic signed [POINT_WIDTH-1:0] x1,
   input  logic signed [POINT_WIDTH-1:0] y1,
   input  logic signed [POINT_WIDTH-1:0] x2,
   input  logic signed [POINT_WIDTH-1:0] y2,
   input  logic signed [POINT_WIDTH-1:0] x3,
   input  logic signed [POINT_WIDTH-1:0] y3,
   input  logic signed [POINT_WIDTH-1:0] x4,
   input  logic signed [POINT_WIDTH-1:0] y4,
   output logic                          hit
);
   localparam int DW  = POINT_WIDTH + 1;
   localparam int PRW = 2 * DW;
   localparam int SW  = PRW + 1;

   logic signed [DW-1:0]  dx12, dy12, dx34, dy34, dx13, dy13;
   logic signed [PRW-1:0] pd0, pd1, pn10, pn11, pn20, pn21;
   logic signed [SW-1:0]  den, num1, num2;
   logic                  den_pos, den_neg, fit_pos, fit_neg;

   assign dx12 = DW'(x2) - DW'(x1);
   assign dy12 = DW'(y2) - DW'(y1);
   assign dx34 = DW'(x4) - DW'(x3);
   assign dy34 = DW'(y4) - DW'(y3);
   assign dx13 = DW'(x1) - DW'(x3);
   assign dy13 = DW'(y1) - DW'(y3);

   assign pd0  = dx12 * dy34;
   assign pd1  = dy12 * dx34;
   assign pn10 = dy13 * dx34;
   assign pn11 = dx13 * dy34;
   assign pn20 = dy13 * dx12;
   assign pn21 = dx13 * dy12;

   assign den  = SW'(pd0) - SW'(pd1);
   assign num1 = SW'(pn10) - SW'(pn11);
   assign num2 = SW'(pn20) - SW'(pn21);

   assign den_neg = den[SW-1];
   assign den_pos = !den[SW-1] && (den != '0);

   assign fit_pos = !num1[SW-1] && (num1 <= den) && !num2[SW-1] && (num2 <= den);
   assign fit_neg = (num1[SW-1] || (num1 == '0)) && (num1 >= den) &&
                    (num2[SW-1] || (num2 == '0)) && (num2 >= den);

   assign hit = (den_pos && fit_pos) || (den_neg && fit_neg);
endmodule

/* src/spc_circ_rect.sv */
// Circle against rectangle: clamp the centre into the rectangle and compare
// squared distance with squared radius. Uses no package items.
module spc_circ_rect #(
   parameter int COORD_WIDTH = 16
) (
   input  logic signed [COORD_WIDTH-1:0] cx,
   input  logic signed [COORD_WIDTH-1:0] cy,
   input  logic signed [COORD_WIDTH-1:0] cr,
   input  logic signed [COORD_WIDTH-1:0] rx,
   input  logic signed [COORD_WIDTH-1:0] ry,
   input  logic signed [COORD_WIDTH-1:0] rw,
   input  logic signed [COORD_WIDTH-1:0] rh,
   output logic                          hit
);
   localparam int EW = COORD_WIDTH + 1;
   localparam int DW = COORD_WIDTH + 2;
   localparam int QW = 2 * DW;
   localparam int RW = 2 * COORD_WIDTH;

   logic signed [EW-1:0]   cx_e, cy_e, lo_x, lo_y, hi_x, hi_y, cl_x, cl_y;
   logic signed [DW-1:0]   dx, dy;
   logic signed [QW-1:0]   sq_x, sq_y;
   logic signed [RW-1:0]   sq_r;
   logic signed [QW:0]     dist_sq;

   assign cx_e = EW'(cx);
   assign cy_e = EW'(cy);
   assign lo_x = EW'(rx);
   assign lo_y = EW'(ry);
   assign hi_x = EW'(rx) + EW'(rw);
   assign hi_y = EW'(ry) + EW'(rh);

   assign cl_x = (cx_e > hi_x) ? hi_x : ((cx_e < lo_x) ? lo_x : cx_e);
   assign cl_y = (cy_e > hi_y) ? hi_y : ((cy_e < lo_y) ? lo_y : cy_e);

   assign dx = DW'(cx_e) - DW'(cl_x);
   assign dy = DW'(cy_e) - DW'(cl_y);

   assign sq_x = dx * dx;
   assign sq_y = dy * dy;
   assign sq_r = cr * cr;

   assign dist_sq = (QW+1)'(sq_x) + (QW+1)'(sq_y);
   assign hit     = dist_sq < (QW+1)'(sq_r);
endmodule

/* src/spc_pair_eval.sv */
// Combinational collision evaluation of one shape pair.
// Depends on spc_pkg, spc_seg_test and spc_circ_rect.
module spc_pair_eval #(
   parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEFAULT
) (
   input  spc_pkg::kind_type             kind_a,
   input  logic signed [COORD_WIDTH-1:0] ax,
   input  logic signed [COORD_WIDTH-1:0] ay,
   input  logic signed [COORD_WIDTH-1:0] ap,
   input  logic signed [COORD_WIDTH-1:0] aq,
   input  spc_pkg::kind_type             kind_b,
   input  logic signed [COORD_WIDTH-1:0] bx,
   input  logic signed [COORD_WIDTH-1:0] by,
   input  logic signed [COORD_WIDTH-1:0] bp,
   input  logic signed [COORD_WIDTH-1:0] bq,
   output logic                          hit
);
   import spc_pkg::*;

   localparam int PW = COORD_WIDTH + 1;
   localparam int NUM_EDGES = 4;

   logic                          pair_rr, pair_ss, pair_sr, pair_cr;
   logic                          seg_is_a, circ_is_a;
   logic signed [PW-1:0]          sx1, sy1, sx2, sy2;
   logic signed [COORD_WIDTH-1:0] rx, ry, rw, rh;
   logic signed [PW-1:0]          ex0, ey0, ex1, ey1;
   logic signed [PW-1:0]          ox1, oy1, ox2, oy2;
   logic signed [PW-1:0]          e3x [NUM_EDGES];
   logic signed [PW-1:0]          e3y [NUM_EDGES];
   logic signed [PW-1:0]          e4x [NUM_EDGES];
   logic signed [PW-1:0]          e4y [NUM_EDGES];
   logic [NUM_EDGES-1:0]          seg_hit;
   logic                          rr_hit, cr_hit;
   logic signed [PW-1:0]          a_right, a_top, b_right, b_top;

   assign pair_rr = (kind_a == KIND_RECT) && (kind_b == KIND_RECT);
   assign pair_ss = (kind_a == KIND_SEG) && (kind_b == KIND_SEG);
   assign pair_sr = ((kind_a == KIND_RECT) && (kind_b == KIND_SEG)) ||
                    ((kind_a == KIND_SEG) && (kind_b == KIND_RECT));
   assign pair_cr = ((kind_a == KIND_RECT) && (kind_b == KIND_CIRCLE)) ||
                    ((kind_a == KIND_CIRCLE) && (kind_b == KIND_RECT));

   assign seg_is_a  = (kind_a == KIND_SEG);
   assign circ_is_a = (kind_a == KIND_CIRCLE);

   assign sx1 = PW'(seg_is_a ? ax : bx);
   assign sy1 = PW'(seg_is_a ? ay : by);
   assign sx2 = PW'(seg_is_a ? ap : bp);
   assign sy2 = PW'(seg_is_a ? aq : bq);

   assign rx = seg_is_a ? bx : ax;
   assign ry = seg_is_a ? by : ay;
   assign rw = seg_is_a ? bp : ap;
   assign rh = seg_is_a ? bq : aq;

   assign ex0 = PW'(rx);
   assign ey0 = PW'(ry);
   assign ex1 = PW'(rx) + PW'(rw);
   assign ey1 = PW'(ry) + PW'(rh);

   assign ox1 = PW'(bx);
   assign oy1 = PW'(by);
   assign ox2 = PW'(bp);
   assign oy2 = PW'(bq);

   // bottom edge, or the second segment on a segment pair
   assign e3x[0] = pair_ss ? ox1 : ex0;
   assign e3y[0] = pair_ss ? oy1 : ey0;
   assign e4x[0] = pair_ss ? ox2 : ex1;
   assign e4y[0] = pair_ss ? oy2 : ey0;
   // left
   assign e3x[1] = ex0;
   assign e3y[1] = ey0;
   assign e4x[1] = ex0;
   assign e4y[1] = ey1;
   // right
   assign e3x[2] = ex1;
   assign e3y[2] = ey0;
   assign e4x[2] = ex1;
   assign e4y[2] = ey1;
   // top
   assign e3x[3] = ex0;
   assign e3y[3] = ey1;
   assign e4x[3] = ex1;
   assign e4y[3] = ey1;

   for (genvar g = 0; g < NUM_EDGES; g++) begin : g_edge
      spc_seg_test #(.POINT_WIDTH(PW)) u_seg (
         .x1(sx1), .y1(sy1), .x2(sx2), .y2(sy2),
         .x3(e3x[g]), .y3(e3y[g]), .x4(e4x[g]), .y4(e4y[g]),
         .hit(seg_hit[g])
      );
   end

   spc_circ_rect #(.COORD_WIDTH(COORD_WIDTH)) u_circ (
      .cx(circ_is_a ? ax : bx),
      .cy(circ_is_a ? ay : by),
      .cr(circ_is_a ? ap : bp),
      .rx(circ_is_a ? bx : ax),
      .ry(circ_is_a ? by : ay),
      .rw(circ_is_a ? bp : ap),
      .rh(circ_is_a ? bq : aq),
      .hit(cr_hit)
   );

   assign a_right = PW'(ax) + PW'(ap);
   assign a_top   = PW'(ay) + PW'(aq);
   assign b_right = PW'(bx) + PW'(bp);
   assign b_top   = PW'(by) + PW'(bq);

   assign rr_hit = (PW'(ax) < b_right) && (a_right > PW'(bx)) &&
                   (PW'(ay) < b_top) && (a_top > PW'(by));

   assign hit = (pair_rr && rr_hit) || (pair_ss && seg_hit[0]) ||
                (pair_sr && (|seg_hit)) || (pair_cr && cr_hit);
endmodule

/* bench/spc_bench_pkg.sv */
// Bench package for the shape pair collision test: pair record, hit predictor, ledger.
// Depends on spc_pkg for the kind codes.
package spc_bench_pkg;
   import spc_pkg::*;

   localparam int COORD_BITS = 16;
   localparam kind_type KIND_UNUSED = 2'd3;

   typedef struct {
      kind_type               kind_a;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] ap;
      logic signed [COORD_BITS-1:0] aq;
      kind_type               kind_b;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic signed [COORD_BITS-1:0] bp;
      logic signed [COORD_BITS-1:0] bq;
   } shape_pair_type;

   function automatic shape_pair_type make_pair(kind_type ka, int ax, int ay, int ap, int aq,
                                                kind_type kb, int bx, int by, int bp, int bq);
      shape_pair_type p;
      p.kind_a = ka;
      p.ax = ax[COORD_BITS-1:0];
      p.ay = ay[COORD_BITS-1:0];
      p.ap = ap[COORD_BITS-1:0];
      p.aq = aq[COORD_BITS-1:0];
      p.kind_b = kb;
      p.bx = bx[COORD_BITS-1:0];
      p.by = by[COORD_BITS-1:0];
      p.bp = bp[COORD_BITS-1:0];
      p.bq = bq[COORD_BITS-1:0];
      return p;
   endfunction

   // Closed-interval parametric test, decided on the sign of the denominator and the numerators against it.
   function automatic bit segments_cross(longint x1, longint y1, longint x2, longint y2,
                                         longint x3, longint y3, longint x4, longint y4);
      longint den, num_a, num_b;
      den   = (x2 - x1) * (y4 - y3) - (y2 - y1) * (x4 - x3);
      num_a = (y1 - y3) * (x4 - x3) - (x1 - x3) * (y4 - y3);
      num_b = (y1 - y3) * (x2 - x1) - (x1 - x3) * (y2 - y1);
      if (den == 0)
         return 1'b0;
      if (den > 0)
         return num_a >= 0 && num_a <= den && num_b >= 0 && num_b <= den;
      return num_a <= 0 && num_a >= den && num_b <= 0 && num_b >= den;
   endfunction

   function automatic bit segment_meets_rect(longint sx0, longint sy0, longint sx1, longint sy1,
                                             longint rx, longint ry, longint rw, longint rh);
      longint x1, y1;
      x1 = rx + rw;
      y1 = ry + rh;
      return segments_cross(sx0, sy0, sx1, sy1, rx, ry, x1, ry) ||
             segments_cross(sx0, sy0, sx1, sy1, rx, ry, rx, y1) ||
             segments_cross(sx0, sy0, sx1, sy1, x1, ry, x1, y1) ||
             segments_cross(sx0, sy0, sx1, sy1, rx, y1, x1, y1);
   endfunction

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      if (v > hi)
         return hi;
      if (v < lo)
         return lo;
      return v;
   endfunction

   function automatic bit circle_meets_rect(longint cx, longint cy, longint radius,
                                            longint rx, longint ry, longint rw, longint rh);
      longint dx, dy;
      dx = cx - clamp_to(cx, rx, rx + rw);
      dy = cy - clamp_to(cy, ry, ry + rh);
      return dx * dx + dy * dy < radius * radius;
   endfunction

   function automatic bit rects_overlap(longint ax, longint ay, longint aw, longint ah,
                                        longint bx, longint by, longint bw, longint bh);
      return ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
   endfunction

   function automatic bit predict_hit(shape_pair_type p);
      longint ax, ay, ap, aq, bx, by, bp, bq;
      ax = longint'(p.ax);
      ay = longint'(p.ay);
      ap = longint'(p.ap);
      aq = longint'(p.aq);
      bx = longint'(p.bx);
      by = longint'(p.by);
      bp = longint'(p.bp);
      bq = longint'(p.bq);
      if (p.kind_a == KIND_RECT && p.kind_b == KIND_RECT)
         return rects_overlap(ax, ay, ap, aq, bx, by, bp, bq);
      if (p.kind_a == KIND_SEG && p.kind_b == KIND_SEG)
         return segments_cross(ax, ay, ap, aq, bx, by, bp, bq);
      if (p.kind_a == KIND_RECT && p.kind_b == KIND_SEG)
         return segment_meets_rect(bx, by, bp, bq, ax, ay, ap, aq);
      if (p.kind_a == KIND_SEG && p.kind_b == KIND_RECT)
         return segment_meets_rect(ax, ay, ap, aq, bx, by, bp, bq);
      if (p.kind_a == KIND_RECT && p.kind_b == KIND_CIRCLE)
         return circle_meets_rect(bx, by, bp, ax, ay, ap, aq);
      if (p.kind_a == KIND_CIRCLE && p.kind_b == KIND_RECT)
         return circle_meets_rect(ax, ay, ap, bx, by, bp, bq);
      return 1'b0;
   endfunction

   class hit_ledger;
      bit pending_hits[$];
      int mismatches;
      int pairs_logged;
      int results_seen;
      int touching;

      function void log_pair(shape_pair_type p);
         bit predicted;
         predicted = predict_hit(p);
         pending_hits.push_back(predicted);
         pairs_logged++;
         if (predicted)
            touching++;
      endfunction

      task report(string what);
         $display("mismatch at result %0d: %s", results_seen, what);
         mismatches++;
      endtask

      task match_hit(logic hit);
         bit predicted;
         if (pending_hits.size() == 0) begin
            report("result with no pair outstanding");
         end else begin
            predicted = pending_hits.pop_front();
            if (hit !== predicted)
               report($sformatf("hit is %b, predicted %b", hit, predicted));
         end
         results_seen++;
      endtask
   endclass

endpackage

/* bench/testbench.sv */
// Testbench for shape_pair_collision_test: directed and random shape pairs,
// random stalls on both channels, hits checked in order against a predictor.
// Depends on spc_pkg, spc_req_if, spc_rsp_if, spc_bench_pkg and the block itself.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import spc_pkg::*;
   import spc_bench_pkg::*;

   localparam int RANDOM_PAIRS = 926;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 500;
   localparam int SETTLE_CYCLES = 8;

   localparam int SPREAD_NEAR = 0;
   localparam int SPREAD_FULL = 1;
   localparam int SPREAD_EDGE = 2;

   logic clock;
   logic reset;

   spc_req_if #(.COORD_WIDTH(COORD_BITS)) req_bus ();
   spc_rsp_if rsp_bus ();

   shape_pair_collision_test #(.COORD_WIDTH(COORD_BITS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hit_ledger ledger = new();

   bit sender_quiet;
   bit receiver_quiet;
   bit hold_wanted;
   bit hold_done;
   int idle_cycles;
   int input_stall_cycles;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      shape_pair_type seen;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.kind_a = req_bus.kind_a;
            seen.ax = req_bus.ax;
            seen.ay = req_bus.ay;
            seen.ap = req_bus.ap;
            seen.aq = req_bus.aq;
            seen.kind_b = req_bus.kind_b;
            seen.bx = req_bus.bx;
            seen.by = req_bus.by;
            seen.bp = req_bus.bp;
            seen.bq = req_bus.bq;
            ledger.log_pair(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready)
            ledger.match_hit(rsp_bus.hit);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_bus.valid && !req_bus.ready)
            input_stall_cycles <= input_stall_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("no transaction for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord(int spread);
      int t;
      case (spread)
         SPREAD_FULL: t = $urandom;
         SPREAD_EDGE: begin
            case ($urandom_range(0, 5))
               0: t = 32767;
               1: t = -32768;
               2: t = 0;
               3: t = -1;
               4: t = 1;
               default: t = $urandom;
            endcase
         end
         default: t = int'($urandom_range(0, 400)) - 200;
      endcase
      return t[COORD_BITS-1:0];
   endfunction

   function automatic shape_pair_type random_pair();
      shape_pair_type p;
      int r, spread;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         p.kind_a = kind_type'($urandom_range(0, 3));
         p.kind_b = kind_type'($urandom_range(0, 3));
      end else begin
         case ($urandom_range(0, 5))
            0: begin p.kind_a = KIND_RECT;   p.kind_b = KIND_RECT;   end
            1: begin p.kind_a = KIND_SEG;    p.kind_b = KIND_SEG;    end
            2: begin p.kind_a = KIND_SEG;    p.kind_b = KIND_RECT;   end
            3: begin p.kind_a = KIND_RECT;   p.kind_b = KIND_SEG;    end
            4: begin p.kind_a = KIND_CIRCLE; p.kind_b = KIND_RECT;   end
            default: begin p.kind_a = KIND_RECT; p.kind_b = KIND_CIRCLE; end
         endcase
      end
      r = $urandom_range(0, 9);
      spread = (r < 2) ? SPREAD_FULL : (r < 3) ? SPREAD_EDGE : SPREAD_NEAR;
      p.ax = pick_coord(spread);
      p.ay = pick_coord(spread);
      p.ap = pick_coord(spread);
      p.aq = pick_coord(spread);
      p.bx = pick_coord(spread);
      p.by = pick_coord(spread);
      p.bp = pick_coord(spread);
      p.bq = pick_coord(spread);
      return p;
   endfunction

   task automatic send_pair(shape_pair_type p);
      int gap;
      gap = sender_quiet ? 0 : idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.kind_a <= p.kind_a;
      req_bus.ax <= p.ax;
      req_bus.ay <= p.ay;
      req_bus.ap <= p.ap;
      req_bus.aq <= p.aq;
      req_bus.kind_b <= p.kind_b;
      req_bus.bx <= p.bx;
      req_bus.by <= p.by;
      req_bus.bp <= p.bp;
      req_bus.bq <= p.bq;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic send_random(int count);
      repeat (count) send_pair(random_pair());
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending_hits.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_wanted && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (receiver_quiet) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            gap = idle_length();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      idle_cycles = 0;
      input_stall_cycles = 0;
      req_bus.valid = 1'b0;
      req_bus.kind_a = KIND_RECT;
      req_bus.ax = '0;
      req_bus.ay = '0;
      req_bus.ap = '0;
      req_bus.aq = '0;
      req_bus.kind_b = KIND_RECT;
      req_bus.bx = '0;
      req_bus.by = '0;
      req_bus.bp = '0;
      req_bus.bq = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_pair(make_pair(KIND_RECT, 0, 0, 10, 10, KIND_RECT, 5, 5, 10, 10));
      send_pair(make_pair(KIND_RECT, 0, 0, 10, 10, KIND_RECT, 10, 0, 5, 5));
      send_pair(make_pair(KIND_RECT, -32768, -32768, 32767, 32767,
                          KIND_RECT, 32767, 32767, -32768, -32768));
      send_pair(make_pair(KIND_RECT, 10, 10, -5, -5, KIND_RECT, 0, 0, 20, 20));
      send_pair(make_pair(KIND_SEG, 0, 0, 10, 10, KIND_SEG, 0, 10, 10, 0));
      send_pair(make_pair(KIND_SEG, 0, 0, 10, 0, KIND_SEG, 0, 5, 10, 5));
      send_pair(make_pair(KIND_SEG, 0, 0, 10, 0, KIND_SEG, 5, 0, 15, 0));
      send_pair(make_pair(KIND_SEG, 0, 0, 10, 10, KIND_SEG, 10, 10, 20, 0));
      send_pair(make_pair(KIND_SEG, -32768, -32768, 32767, 32767,
                          KIND_SEG, -32768, 32767, 32767, -32768));
      send_pair(make_pair(KIND_SEG, -5, 5, 15, 5, KIND_RECT, 0, 0, 10, 10));
      send_pair(make_pair(KIND_RECT, 0, 0, 100, 100, KIND_SEG, 10, 10, 20, 20));
      send_pair(make_pair(KIND_SEG, -5, -5, 0, 0, KIND_RECT, 0, 0, 10, 10));
      send_pair(make_pair(KIND_SEG, 32767, -32768, -32768, 32767,
                          KIND_RECT, -32768, -32768, -1, -1));
      send_pair(make_pair(KIND_CIRCLE, 5, 5, 2, 0, KIND_RECT, 0, 0, 10, 10));
      send_pair(make_pair(KIND_CIRCLE, 15, 5, 5, 0, KIND_RECT, 0, 0, 10, 10));
      send_pair(make_pair(KIND_CIRCLE, 12, 5, -5, 0, KIND_RECT, 0, 0, 10, 10));
      send_pair(make_pair(KIND_RECT, 10, 10, -20, -20, KIND_CIRCLE, 5, 5, 3, -1));
      send_pair(make_pair(KIND_CIRCLE, -32768, -32768, -32768, 32767,
                          KIND_RECT, 32767, 32767, 32767, 32767));
      send_pair(make_pair(KIND_CIRCLE, 0, 0, 10, 0, KIND_CIRCLE, 5, 0, 10, 0));
      send_pair(make_pair(KIND_CIRCLE, 0, 0, 10, 0, KIND_SEG, -5, 0, 5, 0));
      send_pair(make_pair(KIND_SEG, -5, 0, 5, 0, KIND_CIRCLE, 0, 0, 10, 0));
      send_pair(make_pair(KIND_UNUSED, 0, 0, 10, 10, KIND_RECT, 0, 0, 10, 10));
      send_pair(make_pair(KIND_RECT, 0, 0, 10, 10, KIND_UNUSED, 0, 0, 10, 10));
      send_pair(make_pair(KIND_UNUSED, -1, -1, -1, -1, KIND_UNUSED, -1, -1, -1, -1));
      drain_results();

      send_random(400);

      // hold the result side off while pairs keep coming back to back
      sender_quiet = 1'b1;
      hold_wanted = 1'b1;
      send_random(150);
      sender_quiet = 1'b0;
      drain_results();

      sender_quiet = 1'b1;
      receiver_quiet = 1'b1;
      send_random(150);
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;

      send_random(RANDOM_PAIRS - 700);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d shape pairs over all kind pairings, unused kind included",
               ledger.results_seen);
      $display("%0d touching; input stalled for %0d cycles, one result hold-off of %0d cycles",
               ledger.touching, input_stall_cycles, HOLD_CYCLES);
      if (ledger.mismatches == 0 && ledger.pending_hits.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
